// File: design/pfb_pkg.sv
`default_nettype none
package pfb_pkg;

  // Geometry defaults
  localparam int PAGE_COUNT_DEF = 4;
  localparam int PAGE_BYTES_DEF = 128;
  localparam int ROWS_PER_PAGE  = 8;
  localparam int MAX_PAGES      = 8;
  localparam int PAGE_IDX_W     = 3;

  // Flush stream layout
  localparam int CMD_LEN = 4;
  localparam logic [7:0] PAGE_SELECT_BASE = 8'hB0;
  localparam logic [7:0] COLUMN_LOW_CMD   = 8'h00;
  localparam logic [7:0] COLUMN_HIGH_CMD  = 8'h10;
  localparam logic [7:0] POS_CMD_CTRL  = 8'd0;
  localparam logic [7:0] POS_PAGE_SEL  = 8'd1;
  localparam logic [7:0] POS_COL_LOW   = 8'd2;
  localparam logic [7:0] POS_COL_HIGH  = 8'd3;
  localparam logic [7:0] POS_DATA_CTRL = 8'd4;

  // Input operation codes
  localparam logic [1:0] OP_SET_PIXEL = 2'd0;
  localparam logic [1:0] OP_CLEAR     = 2'd1;
  localparam logic [1:0] OP_PULL      = 2'd2;

  // Register file
  localparam int PADDR_W = 3;
  localparam logic REG_CMD_CTRL  = 1'b0;
  localparam logic REG_DATA_CTRL = 1'b1;
  localparam logic [7:0] CMD_CTRL_RESET  = 8'd0;
  localparam logic [7:0] DATA_CTRL_RESET = 8'd64;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_SET,
    CMD_CLEAR,
    CMD_PULL
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [PAGE_IDX_W-1:0] page;
    logic [7:0]            col;
    logic [2:0]            bit_idx;
    logic                  pixel_on;
  } cmd_t;

  typedef struct packed {
    logic [7:0] cmd_ctrl;
    logic [7:0] data_ctrl;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SET_WR,
    ST_CLEAR,
    ST_PULL_RD
  } back_state_e;

endpackage
`default_nettype wire

// File: design/pfb_if.sv
`default_nettype none
// Request channel: one beat per operation
interface pfb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] x;
  logic [7:0] y;
  logic       pixel_on;

  modport source (output valid, op, x, y, pixel_on, input ready);
  modport sink   (input valid, op, x, y, pixel_on, output ready);
endinterface

// Flush channel: one beat per stream byte
interface pfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       transfer_start;
  logic       transfer_end;
  logic       command_transfer;
  logic [2:0] page_index;

  modport source (output valid, out_byte, transfer_start, transfer_end, command_transfer,
                  page_index, input ready);
  modport sink   (input valid, out_byte, transfer_start, transfer_end, command_transfer,
                  page_index, output ready);
endinterface
`default_nettype wire

// File: design/paged_framebuffer_dirty_flush_core.sv
// Paged monochrome frame buffer with a byte-serial flush stream.
// in_ch carries operations: set pixel, clear buffer, pull next flush byte.
// out_ch carries one beat for each pull that yields a stream byte: four
// command bytes, then the data control byte and the page bytes.
// The APB port holds the two control bytes; pready is always high.
// A command or control byte goes from the queue into the output register;
// a page byte passes the registered store read on its way there.
// Throughput: command and control bytes one per cycle while out_ch is not
// stalled; page bytes need a store read, set pixel a store read and write
// back, and clear writes only the pages that held pixels.
// A two-entry queue splits the front from the back, so in_ch keeps taking
// beats while out_ch is stalled until the queue fills; a stalled out_ch
// holds its beat and the back waits on the next pull.
// After reset a clearing pass zeroes the whole store, during which in_ch is
// not ready; all pages then start dirty and empty, and register writes are
// taken throughout.
`default_nettype none
module paged_framebuffer_dirty_flush_core #(
  parameter int PAGE_COUNT = pfb_pkg::PAGE_COUNT_DEF,
  parameter int PAGE_BYTES = pfb_pkg::PAGE_BYTES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  pfb_in_if.sink                           in_ch,
  pfb_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pfb_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  logic [7:0]    cmd_ctrl_q, data_ctrl_q;
  pfb_pkg::cfg_t cfg;
  logic          cfg_we;
  logic          cmd_valid, cmd_ready, init_done;
  pfb_pkg::cmd_t cmd;

  // Register writes on the access phase
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_ctrl_q  <= pfb_pkg::CMD_CTRL_RESET;
      data_ctrl_q <= pfb_pkg::DATA_CTRL_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == pfb_pkg::REG_CMD_CTRL) cmd_ctrl_q  <= pwdata[7:0];
      if (paddr[2] == pfb_pkg::REG_DATA_CTRL) data_ctrl_q <= pwdata[7:0];
    end
  end

  assign prdata = {24'd0, (paddr[2] == pfb_pkg::REG_DATA_CTRL) ? data_ctrl_q : cmd_ctrl_q};

  assign cfg.cmd_ctrl  = cmd_ctrl_q;
  assign cfg.data_ctrl = data_ctrl_q;

  pfb_front #(.PAGE_COUNT(PAGE_COUNT), .PAGE_BYTES(PAGE_BYTES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .init_done_i (init_done),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  pfb_back #(.PAGE_COUNT(PAGE_COUNT), .PAGE_BYTES(PAGE_BYTES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .init_done_o (init_done),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire

// File: design/pfb_ram.sv
`default_nettype none
module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: design/pfb_front.sv
`default_nettype none
module pfb_front #(
  parameter int PAGE_COUNT = pfb_pkg::PAGE_COUNT_DEF,
  parameter int PAGE_BYTES = pfb_pkg::PAGE_BYTES_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pfb_in_if.sink     in_ch,
  input  wire logic  init_done_i,
  output logic       cmd_valid_o,
  input  wire logic  cmd_ready_i,
  output pfb_pkg::cmd_t cmd_o
);

  localparam int QW = $clog2(pfb_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(pfb_pkg::QUEUE_DEPTH + 1);

  pfb_pkg::cmd_t entry_q [pfb_pkg::QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  pfb_pkg::cmd_t cls;
  logic          cls_keep;
  logic          in_range;
  logic          push, pop;

  // Classify the incoming beat
  assign in_range = (9'(in_ch.x) < 9'(PAGE_BYTES)) &&
                    (9'(in_ch.y) < 9'(pfb_pkg::ROWS_PER_PAGE * PAGE_COUNT));

  always_comb begin
    cls.kind     = pfb_pkg::CMD_PULL;
    cls.page     = in_ch.y[5:3];
    cls.col      = in_ch.x;
    cls.bit_idx  = in_ch.y[2:0];
    cls.pixel_on = in_ch.pixel_on;
    cls_keep     = 1'b0;
    case (in_ch.op)
      pfb_pkg::OP_SET_PIXEL: begin
        cls.kind = pfb_pkg::CMD_SET;
        cls_keep = in_range;
      end
      pfb_pkg::OP_CLEAR: begin
        cls.kind = pfb_pkg::CMD_CLEAR;
        cls_keep = 1'b1;
      end
      pfb_pkg::OP_PULL: begin
        cls.kind = pfb_pkg::CMD_PULL;
        cls_keep = 1'b1;
      end
      default: cls_keep = 1'b0;
    endcase
  end

  assign in_ch.ready = init_done_i && (count_q != CW'(pfb_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready && cls_keep;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = entry_q[rd_ptr_q];

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + QW'(1);
      if (push && !pop)      count_q <= count_q + CW'(1);
      else if (pop && !push) count_q <= count_q - CW'(1);
    end
  end

endmodule
`default_nettype wire

// File: design/pfb_back.sv
`default_nettype none
module pfb_back #(
  parameter int PAGE_COUNT = pfb_pkg::PAGE_COUNT_DEF,
  parameter int PAGE_BYTES = pfb_pkg::PAGE_BYTES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pfb_pkg::cfg_t cfg_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire pfb_pkg::cmd_t cmd_i,
  output logic               init_done_o,
  pfb_out_if.source          out_ch
);

  localparam int DEPTH      = PAGE_COUNT * PAGE_BYTES;
  localparam int AW         = $clog2(DEPTH);
  localparam int PW         = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int XW         = $clog2(PAGE_BYTES);
  localparam int STREAM_LEN = pfb_pkg::CMD_LEN + 1 + PAGE_BYTES;

  pfb_pkg::back_state_e state_q, state_d;

  logic [PAGE_COUNT-1:0] dirty_q, dirty_d, empty_q, empty_d;
  logic                  active_q, active_d;
  logic [PW-1:0]         spage_q, spage_d;
  logic [7:0]            pos_q, pos_d;
  logic [PW-1:0]         swp_page_q, swp_page_d;
  logic [XW-1:0]         swp_col_q, swp_col_d;

  logic [AW-1:0] set_addr_q, set_addr_d;
  logic [2:0]    set_bit_q, set_bit_d;
  logic          set_on_q, set_on_d;
  logic [PW-1:0] set_page_q, set_page_d;
  logic          pend_end_q, pend_end_d;
  logic [PW-1:0] pend_page_q, pend_page_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_start_q, out_start_d;
  logic       out_end_q, out_end_d;
  logic       out_cmd_q, out_cmd_d;
  logic [2:0] out_page_q, out_page_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic [PW-1:0] head_page, found_page, eff_page;
  logic          any_dirty;
  logic [7:0]    eff_pos;
  logic [AW-1:0] head_addr, pull_addr, sweep_addr;
  logic          swp_last_col, swp_last_page;

  pfb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Find the lowest dirty page
  always_comb begin
    found_page = '0;
    any_dirty  = 1'b0;
    for (int p = PAGE_COUNT - 1; p >= 0; p--) begin
      if (dirty_q[p]) begin
        found_page = PW'(p);
        any_dirty  = 1'b1;
      end
    end
  end

  assign head_page  = cmd_i.page[PW-1:0];
  assign eff_page   = active_q ? spage_q : found_page;
  assign eff_pos    = active_q ? pos_q : 8'd0;
  assign head_addr  = AW'(32'(head_page) * PAGE_BYTES + 32'(cmd_i.col));
  assign pull_addr  = AW'(32'(eff_page) * PAGE_BYTES +
                          32'(XW'(eff_pos - 8'(pfb_pkg::CMD_LEN + 1))));
  assign sweep_addr = AW'(32'(swp_page_q) * PAGE_BYTES + 32'(swp_col_q));
  assign swp_last_col  = (swp_col_q == XW'(PAGE_BYTES - 1));
  assign swp_last_page = (swp_page_q == PW'(PAGE_COUNT - 1));
  assign init_done_o   = (state_q != pfb_pkg::ST_INIT);

  // Sequence commands from the queue
  always_comb begin
    state_d     = state_q;
    dirty_d     = dirty_q;
    empty_d     = empty_q;
    active_d    = active_q;
    spage_d     = spage_q;
    pos_d       = pos_q;
    swp_page_d  = swp_page_q;
    swp_col_d   = swp_col_q;
    set_addr_d  = set_addr_q;
    set_bit_d   = set_bit_q;
    set_on_d    = set_on_q;
    set_page_d  = set_page_q;
    pend_end_d  = pend_end_q;
    pend_page_d = pend_page_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    out_byte_d  = out_byte_q;
    out_start_d = out_start_q;
    out_end_d   = out_end_q;
    out_cmd_d   = out_cmd_q;
    out_page_d  = out_page_q;
    ram_we      = 1'b0;
    ram_waddr   = sweep_addr;
    ram_wdata   = 8'd0;
    ram_raddr   = head_addr;
    cmd_ready_o = 1'b0;

    case (state_q)
      pfb_pkg::ST_INIT: begin
        // Zero the whole store once after reset
        ram_we = 1'b1;
        if (swp_last_col) begin
          swp_col_d = '0;
          if (swp_last_page) begin
            swp_page_d = '0;
            state_d    = pfb_pkg::ST_IDLE;
          end else begin
            swp_page_d = swp_page_q + PW'(1);
          end
        end else begin
          swp_col_d = swp_col_q + XW'(1);
        end
      end

      pfb_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            pfb_pkg::CMD_SET: begin
              cmd_ready_o = 1'b1;
              set_addr_d  = head_addr;
              set_bit_d   = cmd_i.bit_idx;
              set_on_d    = cmd_i.pixel_on;
              set_page_d  = head_page;
              state_d     = pfb_pkg::ST_SET_WR;
            end
            pfb_pkg::CMD_CLEAR: begin
              cmd_ready_o = 1'b1;
              swp_page_d  = '0;
              swp_col_d   = '0;
              state_d     = pfb_pkg::ST_CLEAR;
            end
            pfb_pkg::CMD_PULL: begin
              ram_raddr = pull_addr;
              if (!out_valid_q || out_ch.ready) begin
                cmd_ready_o = 1'b1;
                if (active_q || any_dirty) begin
                  // Continue the open stream, or start one on the lowest dirty page
                  if (!active_q) begin
                    dirty_d[found_page] = 1'b0;
                  end
                  spage_d = eff_page;
                  if (32'(eff_pos) + 32'd1 >= 32'(STREAM_LEN)) begin
                    active_d = 1'b0;
                    pos_d    = 8'd0;
                  end else begin
                    active_d = 1'b1;
                    pos_d    = eff_pos + 8'd1;
                  end
                  out_page_d  = 3'(eff_page);
                  out_start_d = 1'b0;
                  out_end_d   = 1'b0;
                  out_cmd_d   = 1'b1;
                  case (eff_pos)
                    pfb_pkg::POS_CMD_CTRL: begin
                      out_valid_d = 1'b1;
                      out_byte_d  = cfg_i.cmd_ctrl;
                      out_start_d = 1'b1;
                    end
                    pfb_pkg::POS_PAGE_SEL: begin
                      out_valid_d = 1'b1;
                      out_byte_d  = pfb_pkg::PAGE_SELECT_BASE + 8'(eff_page);
                    end
                    pfb_pkg::POS_COL_LOW: begin
                      out_valid_d = 1'b1;
                      out_byte_d  = pfb_pkg::COLUMN_LOW_CMD;
                    end
                    pfb_pkg::POS_COL_HIGH: begin
                      out_valid_d = 1'b1;
                      out_byte_d  = pfb_pkg::COLUMN_HIGH_CMD;
                      out_end_d   = 1'b1;
                    end
                    pfb_pkg::POS_DATA_CTRL: begin
                      out_valid_d = 1'b1;
                      out_byte_d  = cfg_i.data_ctrl;
                      out_start_d = 1'b1;
                      out_cmd_d   = 1'b0;
                    end
                    default: begin
                      // Page byte: fetch from the store
                      pend_end_d  = (eff_pos == 8'(STREAM_LEN - 1));
                      pend_page_d = eff_page;
                      state_d     = pfb_pkg::ST_PULL_RD;
                    end
                  endcase
                end
              end
            end
            default: cmd_ready_o = 1'b1;
          endcase
        end
      end

      pfb_pkg::ST_SET_WR: begin
        // Write back the modified byte
        ram_we    = 1'b1;
        ram_waddr = set_addr_q;
        if (set_on_q) begin
          ram_wdata = ram_rdata | (8'd1 << set_bit_q);
          empty_d[set_page_q] = 1'b0;
        end else begin
          ram_wdata = ram_rdata & ~(8'd1 << set_bit_q);
        end
        dirty_d[set_page_q] = 1'b1;
        state_d = pfb_pkg::ST_IDLE;
      end

      pfb_pkg::ST_CLEAR: begin
        // Sweep pages that hold set pixels, skip empty ones
        if (empty_q[swp_page_q]) begin
          swp_col_d = '0;
          if (swp_last_page) state_d = pfb_pkg::ST_IDLE;
          else               swp_page_d = swp_page_q + PW'(1);
        end else begin
          ram_we = 1'b1;
          if (swp_last_col) begin
            swp_col_d           = '0;
            empty_d[swp_page_q] = 1'b1;
            dirty_d[swp_page_q] = 1'b1;
            if (swp_last_page) state_d = pfb_pkg::ST_IDLE;
            else               swp_page_d = swp_page_q + PW'(1);
          end else begin
            swp_col_d = swp_col_q + XW'(1);
          end
        end
      end

      pfb_pkg::ST_PULL_RD: begin
        out_valid_d = 1'b1;
        out_byte_d  = ram_rdata;
        out_start_d = 1'b0;
        out_end_d   = pend_end_q;
        out_cmd_d   = 1'b0;
        out_page_d  = 3'(pend_page_q);
        state_d     = pfb_pkg::ST_IDLE;
      end

      default: state_d = pfb_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfb_pkg::ST_INIT;
      dirty_q     <= '1;
      empty_q     <= '1;
      active_q    <= 1'b0;
      spage_q     <= '0;
      pos_q       <= '0;
      swp_page_q  <= '0;
      swp_col_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dirty_q     <= dirty_d;
      empty_q     <= empty_d;
      active_q    <= active_d;
      spage_q     <= spage_d;
      pos_q       <= pos_d;
      swp_page_q  <= swp_page_d;
      swp_col_q   <= swp_col_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    set_addr_q  <= set_addr_d;
    set_bit_q   <= set_bit_d;
    set_on_q    <= set_on_d;
    set_page_q  <= set_page_d;
    pend_end_q  <= pend_end_d;
    pend_page_q <= pend_page_d;
    out_byte_q  <= out_byte_d;
    out_start_q <= out_start_d;
    out_end_q   <= out_end_d;
    out_cmd_q   <= out_cmd_d;
    out_page_q  <= out_page_d;
  end

  assign out_ch.valid            = out_valid_q;
  assign out_ch.out_byte         = out_byte_q;
  assign out_ch.transfer_start   = out_start_q;
  assign out_ch.transfer_end     = out_end_q;
  assign out_ch.command_transfer = out_cmd_q;
  assign out_ch.page_index       = out_page_q;

endmodule
`default_nettype wire
